### hdl/obot_pkg.sv
// Shared types, constants and the sine table builder for the oriented box overlap test.
package obot_pkg;

	localparam int ANGLE_BITS = 12;
	localparam int COORD_BITS = 24;
	localparam int DIM_BITS   = 16;
	localparam int QUARTER    = 1 << (ANGLE_BITS - 2);
	localparam int IDX_W      = ANGLE_BITS - 1;
	localparam int MAG_W      = 15;
	localparam int TRIG_W     = 16;
	localparam int EXT_W      = TRIG_W + DIM_BITS + 1;
	localparam int CDOT_W     = COORD_BITS + TRIG_W + 1;
	localparam int EDOT_W     = EXT_W + TRIG_W + 1;
	localparam int SUM_W      = CDOT_W + 15 + 3;
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = 2;
	localparam int CNT_W      = 3;
	localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

	typedef logic [MAG_W-1:0] sine_rom_t [0:QUARTER];

	// One box in corner units: centre, trig pair and the two half-edge vectors
	typedef struct packed {
		logic signed [COORD_BITS-1:0] cx;
		logic signed [COORD_BITS-1:0] cy;
		logic signed [TRIG_W-1:0]     cs;
		logic signed [TRIG_W-1:0]     sn;
		logic signed [EXT_W-1:0]      ux;
		logic signed [EXT_W-1:0]      uy;
		logic signed [EXT_W-1:0]      vx;
		logic signed [EXT_W-1:0]      vy;
		logic                         len_nz;
		logic                         wid_nz;
	} box_t;

	typedef struct packed {
		box_t veh;
		box_t obs;
	} pair_t;

	typedef struct packed {
		logic             empty;
		logic [CNT_W-1:0] count;
	} fifo_status_t;

	// Quarter-wave sine in Q14 from a truncated Taylor series in Q30
	function automatic sine_rom_t build_sine_rom();
		sine_rom_t          rom;
		logic [63:0]        x;
		logic [63:0]        t;
		logic signed [63:0] s;
		for (int q = 0; q <= QUARTER; q++) begin
			x = (64'(q) * TWO_PI_Q30) >> ANGLE_BITS;
			t = x;
			s = $signed(x);
			for (int n = 1; n <= 7; n++) begin
				t = (((t * x) >> 30) * x) >> 30;
				case (n)
					1: t = t / 64'd6;
					2: t = t / 64'd20;
					3: t = t / 64'd42;
					4: t = t / 64'd72;
					5: t = t / 64'd110;
					6: t = t / 64'd156;
					default: t = t / 64'd210;
				endcase
				if (n % 2 == 1) s = s - $signed(t);
				else s = s + $signed(t);
			end
			if (s < 0) s = 0;
			s = $signed(($unsigned(s) + 64'd32768) >> 16);
			if (s > 16384) s = 16384;
			rom[q] = s[MAG_W-1:0];
		end
		return rom;
	endfunction

	// Fold an angle into {negate, table index}
	function automatic logic [IDX_W:0] sine_addr(input logic [ANGLE_BITS-1:0] a);
		logic [IDX_W-1:0] r;
		logic [IDX_W-1:0] idx;
		r = {1'b0, a[ANGLE_BITS-3:0]};
		idx = a[ANGLE_BITS-2] ? (IDX_W'(QUARTER) - r) : r;
		return {a[ANGLE_BITS-1], idx};
	endfunction

endpackage

### hdl/obot_front.sv
// Front end: accepts pose pairs, looks up sine and cosine, forms box edge vectors.
module obot_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [obot_pkg::COORD_BITS-1:0] vehicle_x,
	input  logic signed [obot_pkg::COORD_BITS-1:0] vehicle_y,
	input  logic [obot_pkg::ANGLE_BITS-1:0]      vehicle_heading,
	input  logic signed [obot_pkg::COORD_BITS-1:0] obstacle_x,
	input  logic signed [obot_pkg::COORD_BITS-1:0] obstacle_y,
	input  logic [obot_pkg::ANGLE_BITS-1:0]      obstacle_heading,
	input  logic [obot_pkg::DIM_BITS-1:0]        obstacle_length,
	input  logic [obot_pkg::DIM_BITS-1:0]        obstacle_width,
	input  logic [obot_pkg::DIM_BITS-1:0]        vehicle_length,
	input  logic [obot_pkg::DIM_BITS-1:0]        vehicle_width,
	input  obot_pkg::fifo_status_t               fifo_status,
	output logic                                 push,
	output obot_pkg::pair_t                      push_data
);

	localparam obot_pkg::sine_rom_t SINE_ROM = obot_pkg::build_sine_rom();

	logic                                   accept;
	logic [obot_pkg::IDX_W:0]               va_s, va_c, oa_s, oa_c;
	logic                                   v_s1, v_s2;
	logic [obot_pkg::MAG_W-1:0]             vs_mag_s1, vc_mag_s1, os_mag_s1, oc_mag_s1;
	logic                                   vs_neg_s1, vc_neg_s1, os_neg_s1, oc_neg_s1;
	logic signed [obot_pkg::COORD_BITS-1:0] vx_s1, vy_s1, ox_s1, oy_s1;
	logic [obot_pkg::DIM_BITS-1:0]          ol_s1, ow_s1;
	logic signed [obot_pkg::TRIG_W-1:0]     vs_t, vc_t, os_t, oc_t;
	logic signed [obot_pkg::DIM_BITS:0]     vl_t, vw_t, ol_t, ow_t;
	obot_pkg::pair_t                        pair_s2;
	logic [obot_pkg::CNT_W+1:0]             pending;

	// Admit only when the queue has room for everything in flight
	assign pending  = (obot_pkg::CNT_W+2)'(fifo_status.count) + (obot_pkg::CNT_W+2)'(v_s1)
	                + (obot_pkg::CNT_W+2)'(v_s2);
	assign in_ready = pending < (obot_pkg::CNT_W+2)'(obot_pkg::FIFO_DEPTH);
	assign accept   = in_valid && in_ready;

	assign va_s = obot_pkg::sine_addr(vehicle_heading);
	assign va_c = obot_pkg::sine_addr(vehicle_heading
	            + obot_pkg::ANGLE_BITS'(obot_pkg::QUARTER));
	assign oa_s = obot_pkg::sine_addr(obstacle_heading);
	assign oa_c = obot_pkg::sine_addr(obstacle_heading
	            + obot_pkg::ANGLE_BITS'(obot_pkg::QUARTER));

	// Advance the valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	// Stage 1: table reads and operand capture
	always_ff @(posedge clk) begin
		if (accept) begin
			vs_mag_s1 <= SINE_ROM[va_s[obot_pkg::IDX_W-1:0]];
			vc_mag_s1 <= SINE_ROM[va_c[obot_pkg::IDX_W-1:0]];
			os_mag_s1 <= SINE_ROM[oa_s[obot_pkg::IDX_W-1:0]];
			oc_mag_s1 <= SINE_ROM[oa_c[obot_pkg::IDX_W-1:0]];
			vs_neg_s1 <= va_s[obot_pkg::IDX_W];
			vc_neg_s1 <= va_c[obot_pkg::IDX_W];
			os_neg_s1 <= oa_s[obot_pkg::IDX_W];
			oc_neg_s1 <= oa_c[obot_pkg::IDX_W];
			vx_s1 <= vehicle_x;
			vy_s1 <= vehicle_y;
			ox_s1 <= obstacle_x;
			oy_s1 <= obstacle_y;
			ol_s1 <= obstacle_length;
			ow_s1 <= obstacle_width;
		end
	end

	// Apply quadrant sign
	assign vs_t = vs_neg_s1 ? -$signed({1'b0, vs_mag_s1}) : $signed({1'b0, vs_mag_s1});
	assign vc_t = vc_neg_s1 ? -$signed({1'b0, vc_mag_s1}) : $signed({1'b0, vc_mag_s1});
	assign os_t = os_neg_s1 ? -$signed({1'b0, os_mag_s1}) : $signed({1'b0, os_mag_s1});
	assign oc_t = oc_neg_s1 ? -$signed({1'b0, oc_mag_s1}) : $signed({1'b0, oc_mag_s1});
	assign vl_t = $signed({1'b0, vehicle_length});
	assign vw_t = $signed({1'b0, vehicle_width});
	assign ol_t = $signed({1'b0, ol_s1});
	assign ow_t = $signed({1'b0, ow_s1});

	// Stage 2: edge vectors u = L(c,s), v = W(-s,c)
	always_ff @(posedge clk) begin
		if (v_s1) begin
			pair_s2.veh.cx     <= vx_s1;
			pair_s2.veh.cy     <= vy_s1;
			pair_s2.veh.cs     <= vc_t;
			pair_s2.veh.sn     <= vs_t;
			pair_s2.veh.ux     <= vc_t * vl_t;
			pair_s2.veh.uy     <= vs_t * vl_t;
			pair_s2.veh.vx     <= -(vs_t * vw_t);
			pair_s2.veh.vy     <= vc_t * vw_t;
			pair_s2.veh.len_nz <= vehicle_length != '0;
			pair_s2.veh.wid_nz <= vehicle_width != '0;
			pair_s2.obs.cx     <= ox_s1;
			pair_s2.obs.cy     <= oy_s1;
			pair_s2.obs.cs     <= oc_t;
			pair_s2.obs.sn     <= os_t;
			pair_s2.obs.ux     <= oc_t * ol_t;
			pair_s2.obs.uy     <= os_t * ol_t;
			pair_s2.obs.vx     <= -(os_t * ow_t);
			pair_s2.obs.vy     <= oc_t * ow_t;
			pair_s2.obs.len_nz <= ol_s1 != '0;
			pair_s2.obs.wid_nz <= ow_s1 != '0;
		end
	end

	assign push      = v_s2;
	assign push_data = pair_s2;

endmodule

### hdl/obot_fifo.sv
// Short queue of box pairs between front and back end.
module obot_fifo (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  obot_pkg::pair_t        push_data,
	input  logic                   pop,
	output obot_pkg::pair_t        head,
	output obot_pkg::fifo_status_t status
);

	obot_pkg::pair_t                mem_q [obot_pkg::FIFO_DEPTH];
	logic [obot_pkg::PTR_W-1:0]     wr_q, rd_q;
	logic [obot_pkg::CNT_W-1:0]     count_q;

	// Track pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			count_q <= count_q + obot_pkg::CNT_W'(push) - obot_pkg::CNT_W'(pop);
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	assign head         = mem_q[rd_q];
	assign status.count = count_q;
	assign status.empty = count_q == '0;

endmodule

### hdl/obot_back.sv
// Back end: projects both boxes on the four axes and flags separation.
module obot_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  obot_pkg::fifo_status_t fifo_status,
	input  obot_pkg::pair_t        head,
	output logic                   pop,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   collides
);

	localparam int CW = obot_pkg::CDOT_W;
	localparam int EW = obot_pkg::EDOT_W;
	localparam int SW = obot_pkg::SUM_W;

	logic                                en;
	logic                                v_b1, v_b2, out_valid_q, collides_q;
	logic signed [obot_pkg::TRIG_W-1:0]  ax [4];
	logic signed [obot_pkg::TRIG_W-1:0]  ay [4];
	logic                                axen [4];
	obot_pkg::box_t                      bx [2];
	logic signed [CW-2:0]  pcx_s1 [4][2];
	logic signed [CW-2:0]  pcy_s1 [4][2];
	logic signed [EW-2:0]  pux_s1 [4][2];
	logic signed [EW-2:0]  puy_s1 [4][2];
	logic signed [EW-2:0]  pvx_s1 [4][2];
	logic signed [EW-2:0]  pvy_s1 [4][2];
	logic                  axen_s1 [4];
	logic signed [CW-1:0]  dc [4][2];
	logic signed [EW-1:0]  du [4][2];
	logic signed [EW-1:0]  dv [4][2];
	logic signed [CW-1:0]  dc_s2 [4][2];
	logic signed [EW-1:0]  du_s2 [4][2];
	logic signed [EW-1:0]  dv_s2 [4][2];
	logic                  axen_s2 [4];
	logic signed [SW-1:0]  lo [4][2];
	logic signed [SW-1:0]  hi [4][2];
	logic                  sep;

	// Stall the whole pipe only when the held result is not taken
	assign en  = !out_valid_q || out_ready;
	assign pop = en && !fifo_status.empty;

	assign bx[0] = head.veh;
	assign bx[1] = head.obs;

	// Axes: vehicle (c,s), (s,-c); obstacle (c,s), (s,-c)
	assign ax[0] = head.veh.cs;  assign ay[0] = head.veh.sn;
	assign ax[1] = head.veh.sn;  assign ay[1] = -head.veh.cs;
	assign ax[2] = head.obs.cs;  assign ay[2] = head.obs.sn;
	assign ax[3] = head.obs.sn;  assign ay[3] = -head.obs.cs;
	assign axen[0] = head.veh.wid_nz;
	assign axen[1] = head.veh.len_nz;
	assign axen[2] = head.obs.wid_nz;
	assign axen[3] = head.obs.len_nz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b1        <= 1'b0;
			v_b2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_b1        <= pop;
			v_b2        <= v_b1;
			out_valid_q <= v_b2;
		end
	end

	// Stage 1: per-axis products of centre and edge vectors
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				axen_s1[k] <= axen[k];
				for (int b = 0; b < 2; b++) begin
					pcx_s1[k][b] <= bx[b].cx * ax[k];
					pcy_s1[k][b] <= bx[b].cy * ay[k];
					pux_s1[k][b] <= bx[b].ux * ax[k];
					puy_s1[k][b] <= bx[b].uy * ay[k];
					pvx_s1[k][b] <= bx[b].vx * ax[k];
					pvy_s1[k][b] <= bx[b].vy * ay[k];
				end
			end
		end
	end

	// Form dot products and edge extents
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			for (int b = 0; b < 2; b++) begin
				dc[k][b] = CW'(pcx_s1[k][b]) + CW'(pcy_s1[k][b]);
				du[k][b] = EW'(pux_s1[k][b]) + EW'(puy_s1[k][b]);
				dv[k][b] = EW'(pvx_s1[k][b]) + EW'(pvy_s1[k][b]);
				if (du[k][b] < 0) du[k][b] = -du[k][b];
				if (dv[k][b] < 0) dv[k][b] = -dv[k][b];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				axen_s2[k] <= axen_s1[k];
				for (int b = 0; b < 2; b++) begin
					dc_s2[k][b] <= dc[k][b];
					du_s2[k][b] <= du[k][b];
					dv_s2[k][b] <= dv[k][b];
				end
			end
		end
	end

	// Interval ends and disjointness test
	always_comb begin
		sep = 1'b0;
		for (int k = 0; k < 4; k++) begin
			for (int b = 0; b < 2; b++) begin
				hi[k][b] = (SW'(dc_s2[k][b]) <<< 15) + SW'(du_s2[k][b]) + SW'(dv_s2[k][b]);
				lo[k][b] = (SW'(dc_s2[k][b]) <<< 15) - SW'(du_s2[k][b]) - SW'(dv_s2[k][b]);
			end
			if (axen_s2[k] && ((hi[k][0] < lo[k][1]) || (hi[k][1] < lo[k][0])))
				sep = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) collides_q <= !sep;
	end

	assign out_valid = out_valid_q;
	assign collides  = collides_q;

endmodule

### hdl/oriented_box_overlap_test_core.sv
// Oriented box overlap test: top level with register port, front end, queue and back end.
// Path from input transfer to result: 2 front stages for table read and edge vectors,
// queue write, 3 back stages. Throughput: one pair per cycle while the output is not
// stalled, set by the fully pipelined projection multipliers.
// Reset: arst_n clears all valid flags and queue pointers at once; vehicle_length
// returns to 1152 and vehicle_width to 512. No clearing pass is needed.
module oriented_box_overlap_test_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [2:0]                           paddr,
	input  logic [31:0]                          pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [obot_pkg::COORD_BITS-1:0] vehicle_x,
	input  logic signed [obot_pkg::COORD_BITS-1:0] vehicle_y,
	input  logic [obot_pkg::ANGLE_BITS-1:0]      vehicle_heading,
	input  logic signed [obot_pkg::COORD_BITS-1:0] obstacle_x,
	input  logic signed [obot_pkg::COORD_BITS-1:0] obstacle_y,
	input  logic [obot_pkg::ANGLE_BITS-1:0]      obstacle_heading,
	input  logic [obot_pkg::DIM_BITS-1:0]        obstacle_length,
	input  logic [obot_pkg::DIM_BITS-1:0]        obstacle_width,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 collides
);

	logic [obot_pkg::DIM_BITS-1:0] vehicle_length_q, vehicle_width_q;
	logic                          push, pop;
	obot_pkg::pair_t               push_data, head;
	obot_pkg::fifo_status_t        fifo_status;

	assign pready = 1'b1;

	// Register writes on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vehicle_length_q <= obot_pkg::DIM_BITS'(1152);
			vehicle_width_q  <= obot_pkg::DIM_BITS'(512);
		end else if (psel && penable && pwrite) begin
			if (paddr[2]) vehicle_width_q <= pwdata[obot_pkg::DIM_BITS-1:0];
			else vehicle_length_q <= pwdata[obot_pkg::DIM_BITS-1:0];
		end
	end

	assign prdata = paddr[2] ? 32'(vehicle_width_q) : 32'(vehicle_length_q);

	obot_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.vehicle_x        (vehicle_x),
		.vehicle_y        (vehicle_y),
		.vehicle_heading  (vehicle_heading),
		.obstacle_x       (obstacle_x),
		.obstacle_y       (obstacle_y),
		.obstacle_heading (obstacle_heading),
		.obstacle_length  (obstacle_length),
		.obstacle_width   (obstacle_width),
		.vehicle_length   (vehicle_length_q),
		.vehicle_width    (vehicle_width_q),
		.fifo_status      (fifo_status),
		.push             (push),
		.push_data        (push_data)
	);

	obot_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.status    (fifo_status)
	);

	obot_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.fifo_status (fifo_status),
		.head        (head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.collides    (collides)
	);

endmodule
